>>> rtl/core/stepper_ramp_pulse_generator_unit_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_UNIT_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define SRPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srpg: implication check failed");

// Next-cycle implication.
`define SRPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srpg: next-cycle check failed");

`endif

>>> rtl/core/srpg_pkg.sv
package srpg_pkg;

   localparam int unsigned TABLE_DEPTH_DEF     = 512;
   localparam int unsigned STEP_COUNT_BITS_DEF = 24;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
   localparam logic [1:0] REG_MM_PER_REV    = 2'd1;
   localparam logic [1:0] REG_RAMP_LENGTH   = 2'd2;
   localparam logic [1:0] REG_DWELL_TICKS   = 2'd3;

   localparam logic [15:0] STEPS_PER_REV_RST = 16'd800;
   localparam logic [15:0] MM_PER_REV_RST    = 16'd75;
   localparam logic [9:0]  RAMP_LENGTH_RST   = 10'd500;
   localparam logic [23:0] DWELL_TICKS_RST   = 24'd500000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] distance_mm;
      logic        direction;
      logic [8:0]  table_index;
      logic [15:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic step_out;
      logic dir_out;
      logic busy_res;
      logic move_done;
      logic start_taken;
   } rsp_item_type;

endpackage

>>> rtl/core/stepper_ramp_pulse_generator_unit.sv
// Stepper ramp pulse generator. Items are tick (one microsecond), start move
// and ramp table write; each item returns one result with the step and
// direction pin levels, busy, move done and start taken. A start converts
// millimetres to steps in a bit-serial unit (a divide, a multiply and a
// second divide) and then runs opening dwell, pulses and closing dwell,
// all paced by ticks. One item is handled at a time: a tick or table write
// goes straight to the result stage, a tick that begins a pulse inside a
// ramp first waits for the registered ramp table read, and an accepted
// start waits for the serial converter. Ramp entries must be written
// before a move reads them.
`include "stepper_ramp_pulse_generator_unit_macros.svh"

module stepper_ramp_pulse_generator_unit
   import srpg_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEF,
   parameter int unsigned STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned RAMP_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned SC     = STEP_COUNT_BITS;
   localparam int unsigned CNT_W  = STEP_COUNT_BITS + 1;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CONV = 2'd1;
   localparam logic [1:0] F_READ = 2'd2;
   localparam logic [1:0] F_FIN  = 2'd3;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_OPEN  = 3'd1;
   localparam logic [2:0] PH_HIGH  = 3'd2;
   localparam logic [2:0] PH_LOW   = 3'd3;
   localparam logic [2:0] PH_CLOSE = 3'd4;

   logic [15:0] spr_ff, spr_in;
   logic [15:0] mpr_ff, mpr_in;
   logic [9:0]  ramp_len_ff, ramp_len_in;
   logic [23:0] dwell_cfg_ff, dwell_cfg_in;

   logic [1:0]    fsm_ff, fsm_in;
   logic [2:0]    phase_ff, phase_in;
   logic [SC-1:0] total_ff, total_in;
   logic [SC-1:0] index_ff, index_in;
   logic [15:0]   hp_ff, hp_in;
   logic [15:0]   ht_ff, ht_in;
   logic [23:0]   dwell_ff, dwell_in;
   logic          dir_ff, dir_in;
   logic          level_ff, level_in;
   logic          done_ff, done_in;
   logic          taken_ff, taken_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              is_tick;
   logic              begin_now;
   logic [RAMP_W-1:0] ramp_eff;
   logic [CNT_W-1:0]  ramp_ext;
   logic [SC-1:0]     begin_idx;
   logic              past_end;
   logic              in_accel;
   logic              in_decel;
   logic [ADDR_W-1:0] rd_addr;
   logic              ram_we;
   logic [15:0]       ram_rdata;
   logic              conv_start;
   logic              conv_done;
   logic [SC-1:0]     conv_steps;
   logic              csr_wr;

   // ---------------- configuration registers ----------------
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      spr_in       = spr_ff;
      mpr_in       = mpr_ff;
      ramp_len_in  = ramp_len_ff;
      dwell_cfg_in = dwell_cfg_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            REG_STEPS_PER_REV: spr_in       = pwdata[15:0];
            REG_MM_PER_REV:    mpr_in       = pwdata[15:0];
            REG_RAMP_LENGTH:   ramp_len_in  = pwdata[9:0];
            REG_DWELL_TICKS:   dwell_cfg_in = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_STEPS_PER_REV: prdata = {16'd0, spr_ff};
         REG_MM_PER_REV:    prdata = {16'd0, mpr_ff};
         REG_RAMP_LENGTH:   prdata = {22'd0, ramp_len_ff};
         REG_DWELL_TICKS:   prdata = {8'd0, dwell_cfg_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------- pulse index and table address ----------------
   always_comb begin
      if (ramp_len_ff == 10'd0) begin
         ramp_eff = RAMP_W'(1);
      end else if (32'(ramp_len_ff) > 32'(TABLE_DEPTH)) begin
         ramp_eff = RAMP_W'(TABLE_DEPTH);
      end else begin
         ramp_eff = RAMP_W'(ramp_len_ff);
      end
   end

   assign ramp_ext  = CNT_W'(ramp_eff);
   assign begin_idx = (phase_ff == PH_LOW) ? (index_ff + SC'(1)) : index_ff;
   assign past_end  = begin_idx >= total_ff;
   assign in_accel  = {1'b0, begin_idx} < ramp_ext;
   assign in_decel  = ({1'b0, begin_idx} + ramp_ext) >= {1'b0, total_ff};
   assign rd_addr   = in_accel ? ADDR_W'(begin_idx)
                               : ADDR_W'(total_ff - begin_idx - SC'(1));

   assign req_stall = fsm_ff != F_IDLE;
   assign accept    = req_valid && !req_stall;
   assign is_tick   = accept && (req_data.req_type == REQ_TICK);
   assign begin_now = is_tick &&
                      (((phase_ff == PH_OPEN) && (dwell_ff == 24'd0)) ||
                       ((phase_ff == PH_LOW) && (ht_ff == 16'd0)));

   // ---------------- item sequencer ----------------
   always_comb begin
      fsm_in       = fsm_ff;
      phase_in     = phase_ff;
      total_in     = total_ff;
      index_in     = index_ff;
      hp_in        = hp_ff;
      ht_in        = ht_ff;
      dwell_in     = dwell_ff;
      dir_in       = dir_ff;
      level_in     = level_ff;
      done_in      = done_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      conv_start   = 1'b0;
      case (fsm_ff)
         F_IDLE: begin
            if (accept) begin
               done_in  = 1'b0;
               taken_in = 1'b0;
               fsm_in   = F_FIN;
               case (req_data.req_type)
                  REQ_TICK: begin
                     case (phase_ff)
                        PH_OPEN: begin
                           if (dwell_ff != 24'd0) begin
                              dwell_in = dwell_ff - 24'd1;
                           end
                        end
                        PH_HIGH: begin
                           if (ht_ff != 16'd0) begin
                              ht_in = ht_ff - 16'd1;
                           end else begin
                              level_in = 1'b0;
                              phase_in = PH_LOW;
                              ht_in    = (hp_ff == 16'd0) ? 16'd0 : hp_ff - 16'd1;
                           end
                        end
                        PH_LOW: begin
                           if (ht_ff != 16'd0) begin
                              ht_in = ht_ff - 16'd1;
                           end
                        end
                        PH_CLOSE: begin
                           if (dwell_ff != 24'd0) begin
                              dwell_in = dwell_ff - 24'd1;
                           end else begin
                              phase_in = PH_IDLE;
                              done_in  = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                     if (begin_now) begin
                        index_in = begin_idx;
                        if (past_end) begin
                           level_in = 1'b0;
                           if (dwell_cfg_ff != 24'd0) begin
                              phase_in = PH_CLOSE;
                              dwell_in = dwell_cfg_ff - 24'd1;
                           end else begin
                              phase_in = PH_IDLE;
                              done_in  = 1'b1;
                           end
                        end else begin
                           level_in = 1'b1;
                           phase_in = PH_HIGH;
                           if (in_accel || in_decel) begin
                              fsm_in = F_READ;
                           end else begin
                              ht_in = (hp_ff == 16'd0) ? 16'd0 : hp_ff - 16'd1;
                           end
                        end
                     end
                  end
                  REQ_START: begin
                     if (phase_ff == PH_IDLE) begin
                        taken_in   = 1'b1;
                        dir_in     = req_data.direction;
                        index_in   = '0;
                        level_in   = 1'b0;
                        dwell_in   = dwell_cfg_ff;
                        phase_in   = PH_OPEN;
                        conv_start = 1'b1;
                        fsm_in     = F_CONV;
                     end
                  end
                  REQ_WRITE: begin
                     ram_we = 32'(req_data.table_index) < 32'(TABLE_DEPTH);
                  end
                  default: ;
               endcase
            end
         end
         F_CONV: begin
            if (conv_done) begin
               total_in = conv_steps;
               fsm_in   = F_FIN;
            end
         end
         F_READ: begin
            hp_in  = ram_rdata;
            ht_in  = (ram_rdata == 16'd0) ? 16'd0 : ram_rdata - 16'd1;
            fsm_in = F_FIN;
         end
         F_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.step_out    = level_ff;
               rsp_data_in.dir_out     = dir_ff;
               rsp_data_in.busy_res    = phase_ff != PH_IDLE;
               rsp_data_in.move_done   = done_ff;
               rsp_data_in.start_taken = taken_ff;
               fsm_in                  = F_IDLE;
            end
         end
         default: begin
            fsm_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff       <= STEPS_PER_REV_RST;
         mpr_ff       <= MM_PER_REV_RST;
         ramp_len_ff  <= RAMP_LENGTH_RST;
         dwell_cfg_ff <= DWELL_TICKS_RST;
         fsm_ff       <= F_IDLE;
         phase_ff     <= PH_IDLE;
         total_ff     <= '0;
         index_ff     <= '0;
         hp_ff        <= '0;
         ht_ff        <= '0;
         dwell_ff     <= '0;
         dir_ff       <= 1'b0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spr_ff       <= spr_in;
         mpr_ff       <= mpr_in;
         ramp_len_ff  <= ramp_len_in;
         dwell_cfg_ff <= dwell_cfg_in;
         fsm_ff       <= fsm_in;
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         hp_ff        <= hp_in;
         ht_ff        <= ht_in;
         dwell_ff     <= dwell_in;
         dir_ff       <= dir_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      done_ff     <= done_in;
      taken_ff    <= taken_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- submodules ----------------
   srpg_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_data.table_index)),
      .wdata (req_data.table_value),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   srpg_conv #(
      .STEP_COUNT_BITS (STEP_COUNT_BITS)
   ) u_conv (
      .clock         (clock),
      .reset         (reset),
      .start         (conv_start),
      .distance_mm   (req_data.distance_mm),
      .steps_per_rev (spr_ff),
      .mm_per_rev    (mpr_ff),
      .done          (conv_done),
      .steps         (conv_steps)
   );

   // ---------------- assertions ----------------
   `SRPG_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_data.move_done, !rsp_data.busy_res)
   `SRPG_ASSERT_IMP(a_taken_quiet, clock, reset, rsp_valid && rsp_data.start_taken, rsp_data.busy_res && !rsp_data.step_out)
   `SRPG_ASSERT_IMP(a_pulse_in_range, clock, reset, (phase_ff == PH_HIGH) || (phase_ff == PH_LOW), index_ff < total_ff)
   `SRPG_ASSERT_NXT(a_start_launch, clock, reset, accept && (req_data.req_type == REQ_START) && (phase_ff == PH_IDLE), (phase_ff == PH_OPEN) && (fsm_ff == F_CONV))

endmodule

>>> rtl/core/srpg_ram.sv
module srpg_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/srpg_conv.sv
// Bit-serial distance to step count: mm / d, then q*s and r*s, then (r*s) / d.
module srpg_conv #(
   parameter int unsigned STEP_COUNT_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                distance_mm,
   input  logic [15:0]                steps_per_rev,
   input  logic [15:0]                mm_per_rev,
   output logic                       done,
   output logic [STEP_COUNT_BITS-1:0] steps
);

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_DIV1 = 3'd1;
   localparam logic [2:0] C_MUL  = 3'd2;
   localparam logic [2:0] C_DIV2 = 3'd3;
   localparam logic [2:0] C_SUM  = 3'd4;

   localparam logic [4:0] HALF_LAST = 5'd15;
   localparam logic [4:0] FULL_LAST = 5'd31;

   logic [2:0]  st_ff, st_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] d_ff, d_in;
   logic [15:0] s_ff, s_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] dv_ff, dv_in;
   logic [31:0] p1_ff, p1_in;
   logic [31:0] p2_ff, p2_in;
   logic        done_ff, done_in;
   logic [STEP_COUNT_BITS-1:0] steps_ff, steps_in;

   logic [16:0] sh_rem;
   logic        ge;
   logic [16:0] step_rem;
   logic [31:0] step_dv;
   logic [32:0] sum_w;

   assign sh_rem   = {rem_ff[15:0], dv_ff[31]};
   assign ge       = sh_rem >= {1'b0, d_ff};
   assign step_rem = ge ? (sh_rem - {1'b0, d_ff}) : sh_rem;
   assign step_dv  = {dv_ff[30:0], ge};
   assign sum_w    = {1'b0, p1_ff} + {1'b0, dv_ff};

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      steps_in = steps_ff;
      done_in  = 1'b0;
      case (st_ff)
         C_IDLE: begin
            if (start) begin
               d_in   = (mm_per_rev == 16'd0) ? 16'd1 : mm_per_rev;
               s_in   = steps_per_rev;
               dv_in  = {distance_mm, 16'd0};
               rem_in = '0;
               p1_in  = '0;
               p2_in  = '0;
               cnt_in = '0;
               st_in  = C_DIV1;
            end
         end
         C_DIV1: begin
            rem_in = step_rem;
            dv_in  = step_dv;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == HALF_LAST) begin
               cnt_in = '0;
               st_in  = C_MUL;
            end
         end
         C_MUL: begin
            p1_in  = {p1_ff[30:0], 1'b0} + (s_ff[15] ? {16'd0, dv_ff[15:0]} : 32'd0);
            p2_in  = {p2_ff[30:0], 1'b0} + (s_ff[15] ? {16'd0, rem_ff[15:0]} : 32'd0);
            s_in   = {s_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == HALF_LAST) begin
               dv_in  = p2_in;
               rem_in = '0;
               cnt_in = '0;
               st_in  = C_DIV2;
            end
         end
         C_DIV2: begin
            rem_in = step_rem;
            dv_in  = step_dv;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == FULL_LAST) begin
               cnt_in = '0;
               st_in  = C_SUM;
            end
         end
         C_SUM: begin
            if ((sum_w >> STEP_COUNT_BITS) != 33'd0) begin
               steps_in = '1;
            end else begin
               steps_in = sum_w[STEP_COUNT_BITS-1:0];
            end
            done_in = 1'b1;
            st_in   = C_IDLE;
         end
         default: begin
            st_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= C_IDLE;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      d_ff     <= d_in;
      s_ff     <= s_in;
      rem_ff   <= rem_in;
      dv_ff    <= dv_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      steps_ff <= steps_in;
   end

   assign done  = done_ff;
   assign steps = steps_ff;

endmodule
